// ----- src/key_edge_record_replay_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Key edge record/replay unit - assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef KEY_EDGE_RECORD_REPLAY_UNIT_ASSERT_SVH
`define KEY_EDGE_RECORD_REPLAY_UNIT_ASSERT_SVH

`ifndef SYNTH
`define KERR_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("kerr assertion failed");
`define KERR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("kerr assertion failed");
`else
`define KERR_ASSERT(label, clk, rstn, ante, cons)
`define KERR_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ----- src/kerr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key edge record/replay package
// Shared constants, opcodes and stream widths.
// ----------------------------------------------------------------------------
package kerr_pkg;

    localparam int KEY_COUNT_DEF   = 9;
    localparam int STORE_DEPTH_DEF = 4096;

    localparam int KEYS_W   = 9;
    localparam int OPCODE_W = 2;
    localparam int LIMIT_W  = 13;
    localparam int FRAMES_W = 13;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = OPCODE_W;
    localparam int M_TDATA_W = 48;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK       = 2'd0,
        OP_REC_START  = 2'd1,
        OP_REC_END    = 2'd2,
        OP_PLAY_START = 2'd3
    } opcode_t;

endpackage

// ----- src/key_edge_record_replay_unit.sv -----
`timescale 1ns / 1ps
// Pipeline: control and frame store access are registered in stage 1, key
// masks and the output register in stage 2.
// Throughput: one item per cycle while m_tready does not stall the output, set
// by one store write and one store read per cycle on the single frame memory.
// Reset: control, counters, masks and handshake state clear; the frame store
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Key edge record/replay unit
// Per-frame key sampler with press/release edges, frame recording and replay.
// ----------------------------------------------------------------------------
`include "key_edge_record_replay_unit_assert.svh"

module key_edge_record_replay_unit #(
    parameter int KEY_COUNT   = kerr_pkg::KEY_COUNT_DEF,
    parameter int STORE_DEPTH = kerr_pkg::STORE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration: record_limit
    input  logic                              cfg_wr_en,
    input  logic [kerr_pkg::LIMIT_W-1:0]      cfg_wr_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [kerr_pkg::S_TDATA_W-1:0]    s_tdata,   // [8:0] live_keys, [15:9] zero
    input  logic [kerr_pkg::S_TUSER_W-1:0]    s_tuser,   // [1:0] opcode
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [kerr_pkg::M_TDATA_W-1:0]    m_tdata    // [8:0] held_keys, [17:9] pressed_keys,
                                                         // [26:18] released_keys,
                                                         // [27] is_recording, [28] is_playing,
                                                         // [41:29] frames_stored, [47:42] zero
);
    import kerr_pkg::*;

    localparam int KW    = (KEY_COUNT < KEYS_W) ? KEY_COUNT : KEYS_W;
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int LW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_RECORD = 2'd1,
        MODE_PLAY   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        K_CMD  = 2'd0,
        K_LIVE = 2'd1,
        K_MEM  = 2'd2,
        K_ZERO = 2'd3
    } kind_t;

    // ---------------- configuration ----------------
    logic [LIMIT_W-1:0] limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // ---------------- stage 1: control and store access ----------------
    mode_t             mode_reg, mode_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    kind_t             kind;
    logic              mem_we;
    logic              s_accept;
    logic              out_free;
    logic [KW-1:0]     live_eff;
    logic [LW-1:0]     limit_ext;
    logic [LW-1:0]     lim_eff;
    opcode_t           op;

    logic              p_valid_reg;
    kind_t             p_kind_reg;
    logic [KW-1:0]     p_live_reg;
    logic              p_rec_reg;
    logic              p_play_reg;
    logic [CNT_W-1:0]  p_cnt_reg;

    logic              m_valid_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !p_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign op       = opcode_t'(s_tuser);
    assign live_eff = s_tdata[KW-1:0];

    assign limit_ext = LW'(limit_reg);
    assign lim_eff   = (limit_ext > LW'(STORE_DEPTH)) ? LW'(STORE_DEPTH) : limit_ext;

    always_comb begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        pos_next  = pos_reg;
        kind      = K_CMD;
        mem_we    = 1'b0;
        if (s_accept) begin
            unique case (op)
                OP_TICK: begin
                    unique case (mode_reg)
                        MODE_PLAY: begin
                            if (pos_reg < cnt_reg) begin
                                kind     = K_MEM;
                                pos_next = pos_reg + 1'b1;
                            end else begin
                                kind      = K_ZERO;
                                mode_next = MODE_NORMAL;
                            end
                        end
                        MODE_RECORD: begin
                            kind = K_LIVE;
                            if (LW'(cnt_reg) < lim_eff) begin
                                mem_we   = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        default: begin
                            kind = K_LIVE;
                        end
                    endcase
                end
                OP_REC_START: begin
                    mode_next = MODE_RECORD;
                    cnt_next  = '0;
                end
                OP_REC_END: begin
                    mode_next = MODE_NORMAL;
                end
                OP_PLAY_START: begin
                    mode_next = MODE_PLAY;
                    pos_next  = '0;
                end
                default: begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_NORMAL;
            cnt_reg     <= '0;
            pos_reg     <= '0;
            p_valid_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            pos_reg  <= pos_next;
            if (s_accept) begin
                p_valid_reg <= 1'b1;
            end else if (out_free) begin
                p_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p_kind_reg <= kind;
            p_live_reg <= live_eff;
            p_rec_reg  <= (mode_next == MODE_RECORD);
            p_play_reg <= (mode_next == MODE_PLAY);
            p_cnt_reg  <= cnt_next;
        end
    end

    // frame store; record writes and replay reads never fall on adjacent items
    logic [KW-1:0] mem [STORE_DEPTH];
    logic [KW-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[cnt_reg[AW-1:0]] <= live_eff;
        end
        if (s_accept) begin
            rd_reg <= mem[pos_reg[AW-1:0]];
        end
    end

    // ---------------- stage 2: masks, edges, output register ----------------
    logic [KW-1:0]        mask_reg, mask_next;
    logic [KW-1:0]        press_reg, press_next;
    logic [KW-1:0]        rel_reg, rel_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 advance;

    assign advance = p_valid_reg && out_free;

    always_comb begin
        unique case (p_kind_reg)
            K_LIVE:  mask_next = p_live_reg;
            K_MEM:   mask_next = rd_reg;
            K_ZERO:  mask_next = '0;
            default: mask_next = mask_reg;
        endcase
        if (p_kind_reg == K_CMD) begin
            press_next = press_reg;
            rel_next   = rel_reg;
        end else begin
            press_next = (mask_reg ^ mask_next) & mask_next;
            rel_next   = (mask_reg ^ mask_next) & mask_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            press_reg   <= '0;
            rel_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                mask_reg  <= mask_next;
                press_reg <= press_next;
                rel_reg   <= rel_next;
            end
            if (out_free) begin
                m_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= {6'd0, FRAMES_W'(p_cnt_reg), p_play_reg, p_rec_reg,
                           KEYS_W'(rel_next), KEYS_W'(press_next), KEYS_W'(mask_next)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- assertions ----------------
    `KERR_ASSERT(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(STORE_DEPTH))
    `KERR_ASSERT(a_pos_bound, aclk, aresetn, mode_reg == MODE_PLAY, pos_reg <= cnt_reg)
    `KERR_ASSERT(a_we_record, aclk, aresetn, mem_we, mode_reg == MODE_RECORD && s_accept)
    `KERR_ASSERT_NEXT(a_stage_hold, aclk, aresetn, p_valid_reg && !out_free, p_valid_reg)

endmodule

// ----- bench/kerr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key edge record/replay checker
// Watches the input and result streams of the key edge record/replay unit.
// For each input transfer it works out the expected key report from its own
// copy of the mode, key masks, frame store and recording limit. It compares
// every result transfer, field by field, with the oldest report still owed.
// It counts mismatches and the reports still outstanding.
// ----------------------------------------------------------------------------
module kerr_checker
    import kerr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [LIMIT_W-1:0]   cfg_wr_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   mismatches,
    output int                   outstanding
);

    typedef enum logic [1:0] {
        KM_LIVE,
        KM_RECORD,
        KM_REPLAY
    } key_mode_t;

    // laid out as m_tdata, lowest field last
    typedef struct packed {
        logic [5:0]          pad;
        logic [FRAMES_W-1:0] frames;
        logic                playing;
        logic                recording;
        logic [KEYS_W-1:0]   released;
        logic [KEYS_W-1:0]   pressed;
        logic [KEYS_W-1:0]   held;
    } key_report_t;

    key_mode_t           key_mode;
    logic [KEYS_W-1:0]   held_mask;
    logic [KEYS_W-1:0]   press_mask;
    logic [KEYS_W-1:0]   release_mask;
    logic [KEYS_W-1:0]   frame_mem [STORE_DEPTH_DEF];
    logic [FRAMES_W-1:0] frames_kept;
    logic [FRAMES_W-1:0] replay_pos;
    logic [LIMIT_W-1:0]  limit_copy;

    key_report_t owed_reports[$];
    int          fail_total = 0;
    int          owed_total = 0;

    assign mismatches  = fail_total;
    assign outstanding = owed_total;

    function automatic key_report_t advance_keys(opcode_t op, logic [KEYS_W-1:0] live);
        key_report_t        r;
        logic [KEYS_W-1:0]  prev;
        logic [LIMIT_W-1:0] cap;
        case (op)
            OP_TICK: begin
                prev = held_mask;
                if (key_mode == KM_REPLAY) begin
                    if (replay_pos < frames_kept) begin
                        held_mask  = frame_mem[replay_pos[11:0]];
                        replay_pos = replay_pos + 1'b1;
                    end else begin
                        held_mask = '0;
                        key_mode  = KM_LIVE;
                    end
                end else begin
                    held_mask = live;
                    if (key_mode == KM_RECORD) begin
                        cap = (limit_copy > STORE_DEPTH_DEF) ? LIMIT_W'(STORE_DEPTH_DEF)
                                                             : limit_copy;
                        if (frames_kept < cap) begin
                            frame_mem[frames_kept[11:0]] = live;
                            frames_kept = frames_kept + 1'b1;
                        end
                    end
                end
                press_mask   = ~prev & held_mask;
                release_mask = prev & ~held_mask;
            end
            OP_REC_START: begin
                key_mode    = KM_RECORD;
                frames_kept = '0;
            end
            OP_REC_END: begin
                key_mode = KM_LIVE;
            end
            default: begin
                replay_pos = '0;
                key_mode   = KM_REPLAY;
            end
        endcase
        r           = '0;
        r.held      = held_mask;
        r.pressed   = press_mask;
        r.released  = release_mask;
        r.recording = (key_mode == KM_RECORD);
        r.playing   = (key_mode == KM_REPLAY);
        r.frames    = frames_kept;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            fail_total++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        key_report_t want;
        key_report_t got;
        if (!aresetn) begin
            key_mode     = KM_LIVE;
            held_mask    = '0;
            press_mask   = '0;
            release_mask = '0;
            frames_kept  = '0;
            replay_pos   = '0;
            limit_copy   = LIMIT_RESET;
            owed_reports.delete();
        end else begin
            if (cfg_wr_en)
                limit_copy = cfg_wr_data;
            if (s_tvalid && s_tready)
                owed_reports.push_back(advance_keys(opcode_t'(s_tuser), s_tdata[KEYS_W-1:0]));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (owed_reports.size() == 0) begin
                    fail_total++;
                    $display("%0t: result %h with none expected", $time, m_tdata);
                end else begin
                    want = owed_reports.pop_front();
                    check_field("held_keys", want.held, got.held);
                    check_field("pressed_keys", want.pressed, got.pressed);
                    check_field("released_keys", want.released, got.released);
                    check_field("is_recording", want.recording, got.recording);
                    check_field("is_playing", want.playing, got.playing);
                    check_field("frames_stored", want.frames, got.frames);
                    check_field("padding", want.pad, got.pad);
                end
            end
        end
        owed_total = owed_reports.size();
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key edge record/replay testbench
// Drives key ticks and record/playback commands into the unit. A directed
// opening covers the edge and mode corner cases, then a longer recording
// runs under a limit above the store depth. Random record/replay sessions
// follow, mixed with plain ticks and stray commands. The recording limit is
// rewritten between phases, and both stream sides stall at random. Checking
// is done by kerr_checker.
// ----------------------------------------------------------------------------
module tb;
    import kerr_pkg::*;

    localparam int LATENCY     = 4;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 1420;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [LIMIT_W-1:0]   cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int   mismatches;
    int   outstanding;
    int   items_sent;
    int   cycles;
    logic calm;

    key_edge_record_replay_unit i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    kerr_checker i_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 12);
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [KEYS_W-1:0] random_keys();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return KEYS_W'(1 << $urandom_range(KEYS_W - 1));
            default: return KEYS_W'($urandom);
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] random_limit();
        case ($urandom_range(7))
            0:       return '0;
            1:       return LIMIT_W'(1);
            2:       return LIMIT_W'(STORE_DEPTH_DEF);
            3:       return '1;
            4:       return LIMIT_W'($urandom);
            default: return LIMIT_W'($urandom_range(40));
        endcase
    endfunction

    task automatic send_item(input opcode_t op, input logic [KEYS_W-1:0] keys);
        while (!calm && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - KEYS_W){1'b0}}, keys};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    // hold off until every report has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge aclk);
        while (outstanding != 0);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int first_random;
        int takes;
        int replays;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_TICK;
        calm        = 1'b0;
        items_sent  = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // edges, idle commands, empty playback, re-arm and early playback
        send_item(OP_TICK, 9'h1FF);
        send_item(OP_TICK, 9'h000);
        send_item(OP_TICK, 9'h155);
        send_item(OP_TICK, 9'h0AA);
        send_item(OP_REC_END, 9'h000);
        send_item(OP_PLAY_START, 9'h1FF);
        send_item(OP_TICK, 9'h1FF);
        send_item(OP_REC_START, 9'h000);
        send_item(OP_TICK, 9'h1FF);
        send_item(OP_TICK, 9'h001);
        send_item(OP_TICK, 9'h100);
        send_item(OP_REC_START, 9'h000);
        send_item(OP_TICK, 9'h0F0);
        send_item(OP_TICK, 9'h00F);
        send_item(OP_PLAY_START, 9'h000);
        send_item(OP_TICK, 9'h1FF);
        send_item(OP_TICK, 9'h000);
        send_item(OP_TICK, 9'h1FF);
        send_item(OP_REC_START, 9'h000);
        send_item(OP_TICK, 9'h03C);
        send_item(OP_PLAY_START, 9'h000);
        send_item(OP_REC_END, 9'h000);
        send_item(OP_TICK, 9'h1C3);

        // zero limit: nothing stored
        write_limit('0);
        send_item(OP_REC_START, 9'h000);
        send_item(OP_TICK, 9'h1FF);
        send_item(OP_PLAY_START, 9'h000);
        send_item(OP_TICK, 9'h0AA);

        // small limit reached, extra ticks still move the keys
        write_limit(LIMIT_W'(2));
        send_item(OP_REC_START, 9'h000);
        repeat (4) send_item(OP_TICK, random_keys());
        send_item(OP_REC_END, 9'h000);
        send_item(OP_PLAY_START, 9'h000);
        repeat (3) send_item(OP_TICK, random_keys());

        // limit above the store depth, saturated to the depth
        write_limit('1);
        send_item(OP_REC_START, 9'h000);
        repeat (64) send_item(OP_TICK, random_keys());
        send_item(OP_REC_END, 9'h000);
        send_item(OP_PLAY_START, 9'h000);
        repeat (24) send_item(OP_TICK, random_keys());
        send_item(OP_REC_END, 9'h000);
        write_limit(LIMIT_W'(STORE_DEPTH_DEF));

        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            calm = (items_sent - first_random >= 600) && (items_sent - first_random < 900);
            if ((items_sent - first_random) % 150 < 8 && $urandom_range(3) == 0)
                write_limit(random_limit());
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
                    send_item(OP_REC_START, random_keys());
                    takes = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
                    repeat (takes) send_item(OP_TICK, random_keys());
                    if ($urandom_range(3) == 0) begin
                        send_item(OP_REC_END, random_keys());
                        repeat ($urandom_range(3)) send_item(OP_TICK, random_keys());
                    end
                    send_item(OP_PLAY_START, random_keys());
                    replays = $urandom_range(takes + 3);
                    repeat (replays) begin
                        if ($urandom_range(24) == 0)
                            send_item(opcode_t'($urandom_range(3)), random_keys());
                        send_item(OP_TICK, random_keys());
                    end
                end
                11, 12, 13, 14, 15: begin
                    repeat ($urandom_range(1, 10)) send_item(OP_TICK, random_keys());
                end
                default: begin
                    repeat ($urandom_range(1, 6))
                        send_item(opcode_t'($urandom_range(3)), random_keys());
                end
            endcase
        end
        calm = 1'b0;

        drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
